/* sv/mdec_pkg.sv */
`default_nettype none

package mdec_pkg;

	// default and upper bound of the longest code, in symbols
	localparam int MAX_CODE_SYMBOLS_DEF = 4;
	localparam int MAX_CODE_SYMBOLS_TOP = 6;

	// slot field in a queue entry is sized for the longest supported code
	localparam int SLOT_FIELD_W = MAX_CODE_SYMBOLS_TOP + 1;

	// entries in the queue between front and back, a power of two
	localparam int QUEUE_DEPTH = 4;

	// stream characters
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_DASH  = 8'h5F;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_NONE  = 8'h00;

	typedef enum logic [1:0] {
		KIND_LETTER = 2'd0,
		KIND_SPACE  = 2'd1,
		KIND_ERROR  = 2'd2,
		KIND_END    = 2'd3
	} res_kind_t;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_EMIT   = 2'd2
	} cmd_op_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] symbol_char;
		logic       end_of_message;
		logic [2:0] entry_length;
		logic [3:0] entry_pattern;
		logic [7:0] entry_letter;
	} in_item_t;

	typedef struct packed {
		res_kind_t  result_kind;
		logic [7:0] out_char;
		logic       message_done;
	} out_item_t;

	// work handed from the front to the back
	typedef struct packed {
		cmd_op_t                 op;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [7:0]              chr;
		res_kind_t               kind;
		logic                    done;
	} cmd_t;

	// queue status seen by the front
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

/* sv/mdec_fifo.sv */
`default_nettype none

module mdec_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mdec_pkg::cmd_t push_cmd,
	input  wire logic           pop,
	output mdec_pkg::cmd_t      head_cmd,
	output mdec_pkg::q_stat_t   stat
);
	import mdec_pkg::*;

	localparam int PtrW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	cmd_t            slots_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign head_cmd   = slots_q[rd_ptr_q];
	assign stat.full  = (count_q == CntW'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

`default_nettype wire

/* sv/mdec_front.sv */
`default_nettype none

module mdec_front #(
	parameter int MAX_CODE_SYMBOLS = mdec_pkg::MAX_CODE_SYMBOLS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire mdec_pkg::in_item_t in_data,
	input  wire mdec_pkg::q_stat_t  q_stat,
	output logic                    push,
	output mdec_pkg::cmd_t          push_cmd
);
	import mdec_pkg::*;

	localparam int TableDepth = (1 << (MAX_CODE_SYMBOLS + 1)) - 2;
	localparam int SlotW      = $clog2(TableDepth);
	localparam int LenW       = $clog2(MAX_CODE_SYMBOLS + 1);
	localparam int SumW       = MAX_CODE_SYMBOLS + 2;

	// direct index of a code: 2^len - 2 + pattern
	function automatic logic [SlotW-1:0] slot_of(
		input logic [LenW-1:0]             len,
		input logic [MAX_CODE_SYMBOLS-1:0] pat
	);
		logic [SumW-1:0] one_hot;
		logic [SumW-1:0] mask;
		logic [SumW-1:0] sum;
		one_hot = SumW'(1) << len;
		mask    = one_hot - SumW'(1);
		sum     = one_hot - SumW'(2) + (SumW'(pat) & mask);
		return sum[SlotW-1:0];
	endfunction

	logic [TableDepth-1:0]       valid_q;
	logic [LenW-1:0]             code_len_q;
	logic [MAX_CODE_SYMBOLS-1:0] code_bits_q;
	logic                        code_inv_q;
	logic [1:0]                  space_run_q;
	logic                        err_q;

	logic [LenW-1:0]             len_d;
	logic [MAX_CODE_SYMBOLS-1:0] bits_d;
	logic                        inv_d;
	logic [1:0]                  run_d;
	logic                        err_d;

	logic                        accept;
	logic                        ld_ok;
	logic [SlotW-1:0]            ld_slot;
	logic                        ld_new;
	logic                        is_sym;
	logic                        is_space;
	logic [LenW-1:0]             eff_len;
	logic [MAX_CODE_SYMBOLS-1:0] eff_bits;
	logic                        eff_inv;
	logic [SlotW-1:0]            close_slot;
	logic                        close_ok;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// load side: first write of a slot wins
	assign ld_ok   = (in_data.entry_length != 3'd0)
		&& (in_data.entry_length <= 3'(MAX_CODE_SYMBOLS));
	assign ld_slot = slot_of(LenW'(in_data.entry_length),
		MAX_CODE_SYMBOLS'(in_data.entry_pattern));
	assign ld_new  = in_data.operation && ld_ok && !valid_q[ld_slot];

	// classify the stream character
	assign is_sym   = (in_data.symbol_char == CHAR_DOT) || (in_data.symbol_char == CHAR_DASH);
	assign is_space = (in_data.symbol_char == CHAR_SPACE);

	// code after this character, before any clearing
	always_comb begin
		eff_len  = code_len_q;
		eff_bits = code_bits_q;
		eff_inv  = code_inv_q;
		if (is_sym) begin
			if (code_len_q < LenW'(MAX_CODE_SYMBOLS)) begin
				if (in_data.symbol_char == CHAR_DASH) begin
					eff_bits = code_bits_q | (MAX_CODE_SYMBOLS'(1) << code_len_q);
				end
				eff_len = code_len_q + LenW'(1);
			end else begin
				eff_inv = 1'b1;
			end
		end else if (!is_space) begin
			eff_inv = 1'b1;
		end
	end

	// closing check against the valid map
	assign close_slot = slot_of(eff_len, eff_bits);
	assign close_ok   = !eff_inv && (eff_len != '0) && valid_q[close_slot];

	// next decode state and the command for the back
	always_comb begin
		len_d    = code_len_q;
		bits_d   = code_bits_q;
		inv_d    = code_inv_q;
		run_d    = space_run_q;
		err_d    = err_q;
		push     = 1'b0;
		push_cmd = '{op: CMD_EMIT, slot: '0, chr: CHAR_NONE, kind: KIND_ERROR, done: 1'b0};
		if (accept) begin
			if (in_data.operation) begin
				if (ld_new) begin
					push          = 1'b1;
					push_cmd.op   = CMD_WRITE;
					push_cmd.slot = SLOT_FIELD_W'(ld_slot);
					push_cmd.chr  = in_data.entry_letter;
				end
			end else if (err_q) begin
				// suppressed message: only the end marker goes out
				if (in_data.end_of_message) begin
					push          = 1'b1;
					push_cmd.kind = KIND_END;
					push_cmd.done = 1'b1;
					len_d         = '0;
					bits_d        = '0;
					inv_d         = 1'b0;
					run_d         = 2'd0;
					err_d         = 1'b0;
				end
			end else if (in_data.end_of_message) begin
				// final character: a space always ends the message with an error result
				push          = 1'b1;
				push_cmd.done = 1'b1;
				if (!is_space && close_ok) begin
					push_cmd.op   = CMD_LOOKUP;
					push_cmd.slot = SLOT_FIELD_W'(close_slot);
					push_cmd.kind = KIND_LETTER;
				end
				len_d  = '0;
				bits_d = '0;
				inv_d  = 1'b0;
				run_d  = 2'd0;
				err_d  = 1'b0;
			end else begin
				len_d  = eff_len;
				bits_d = eff_bits;
				inv_d  = eff_inv;
				if (is_space) begin
					push = 1'b1;
					case (space_run_q)
						2'd0: begin
							if (close_ok) begin
								push_cmd.op   = CMD_LOOKUP;
								push_cmd.slot = SLOT_FIELD_W'(close_slot);
								push_cmd.kind = KIND_LETTER;
							end else begin
								err_d = 1'b1;
							end
							len_d  = '0;
							bits_d = '0;
							inv_d  = 1'b0;
							run_d  = 2'd1;
						end
						2'd1: begin
							push_cmd.kind = KIND_SPACE;
							push_cmd.chr  = CHAR_SPACE;
							run_d         = 2'd2;
						end
						default: begin
							err_d = 1'b1;
						end
					endcase
				end else begin
					run_d = 2'd0;
				end
			end
		end
	end

	// decode state and valid map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			code_len_q  <= '0;
			code_bits_q <= '0;
			code_inv_q  <= 1'b0;
			space_run_q <= 2'd0;
			err_q       <= 1'b0;
		end else begin
			if (accept && ld_new) begin
				valid_q[ld_slot] <= 1'b1;
			end
			code_len_q  <= len_d;
			code_bits_q <= bits_d;
			code_inv_q  <= inv_d;
			space_run_q <= run_d;
			err_q       <= err_d;
		end
	end

endmodule

`default_nettype wire

/* sv/mdec_back.sv */
`default_nettype none

module mdec_back #(
	parameter int MAX_CODE_SYMBOLS = mdec_pkg::MAX_CODE_SYMBOLS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mdec_pkg::cmd_t    head_cmd,
	input  wire mdec_pkg::q_stat_t q_stat,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output mdec_pkg::out_item_t    out_data
);
	import mdec_pkg::*;

	localparam int TableDepth = (1 << (MAX_CODE_SYMBOLS + 1)) - 2;
	localparam int SlotW      = $clog2(TableDepth);

	logic [7:0]       letters [TableDepth];
	logic [SlotW-1:0] slot;
	logic             advance;
	logic             valid_s1;
	cmd_t             cmd_s1;
	logic [7:0]       letter_s1;

	assign slot    = head_cmd.slot[SlotW-1:0];
	assign advance = !valid_s1 || out_ready;
	assign pop     = !q_stat.empty && advance;

	// letter store: loads write, lookups read into the output stage
	always_ff @(posedge clk) begin
		if (pop) begin
			if (head_cmd.op == CMD_WRITE) begin
				letters[slot] <= head_cmd.chr;
			end else begin
				letter_s1 <= letters[slot];
			end
			cmd_s1 <= head_cmd;
		end
	end

	// output stage occupancy; writes leave no result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pop && (head_cmd.op != CMD_WRITE);
		end
	end

	// result fields
	always_comb begin
		case (cmd_s1.op)
			CMD_LOOKUP: begin
				out_data.result_kind  = KIND_LETTER;
				out_data.out_char     = letter_s1;
				out_data.message_done = cmd_s1.done;
			end
			CMD_EMIT: begin
				out_data.result_kind  = cmd_s1.kind;
				out_data.out_char     = cmd_s1.chr;
				out_data.message_done = cmd_s1.done;
			end
			default: begin
				out_data.result_kind  = KIND_ERROR;
				out_data.out_char     = CHAR_NONE;
				out_data.message_done = 1'b0;
			end
		endcase
	end

	assign out_valid = valid_s1;

endmodule

`default_nettype wire

/* sv/morse_symbol_stream_decoder_top.sv */
`default_nettype none

// channel   direction  handshake              payload
// input     in         in_valid / in_ready    in_data  (mdec_pkg::in_item_t)
// output    out        out_valid / out_ready  out_data (mdec_pkg::out_item_t)
//
// one item per cycle while the queue is not full; a result passes the front decode,
// the queue, then the letter store read in the output stage.
// a four-entry queue parts the front from the back; in_ready drops only when
// it is full, so an output stall reaches the input after four queued items.
// reset clears the valid map and decode state; the letter store is not cleared.
// load items take a pop from the queue for the store write but give no transfer.

module morse_symbol_stream_decoder_top #(
	parameter int MAX_CODE_SYMBOLS = mdec_pkg::MAX_CODE_SYMBOLS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire mdec_pkg::in_item_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output mdec_pkg::out_item_t     out_data
);
	import mdec_pkg::*;

	logic    push;
	logic    pop;
	cmd_t    push_cmd;
	cmd_t    head_cmd;
	q_stat_t q_stat;

	mdec_front #(
		.MAX_CODE_SYMBOLS(MAX_CODE_SYMBOLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mdec_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.stat     (q_stat)
	);

	mdec_back #(
		.MAX_CODE_SYMBOLS(MAX_CODE_SYMBOLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_cmd  (head_cmd),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// queue never overflows or underflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// end marker only closes a message
	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.result_kind == KIND_END) |-> out_data.message_done)
		else $error("end marker without message_done");

	// word space carries the space character, error and end carry none
	a_fixed_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.result_kind != KIND_LETTER)
		|-> (out_data.out_char == CHAR_SPACE && out_data.result_kind == KIND_SPACE)
		|| (out_data.out_char == CHAR_NONE && out_data.result_kind != KIND_SPACE))
		else $error("wrong character on non-letter result");

endmodule

`default_nettype wire
